>>> src/round_robin_priority_scheduler_top_defines.svh
// Assertion macros for the ready-queue scheduler.
// Clocked on clk and disabled while arst_n is low; define ASSERT_OFF to drop them.
`ifndef ROUND_ROBIN_PRIORITY_SCHEDULER_TOP_DEFINES_SVH
`define ROUND_ROBIN_PRIORITY_SCHEDULER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define RRPS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
`define RRPS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define RRPS_ASSERT_SAME(label, ante, cons, msg)
`define RRPS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/rrps_pkg.sv
// Shared types and codes for the ready-queue scheduler.
// No dependencies.
`timescale 1ns / 1ps

package rrps_pkg;

	localparam int PID_W = 22;
	localparam int PRI_W = 8;
	localparam int OP_W  = 3;
	localparam int EV_W  = 3;
	localparam int TICK_W = 16;

	localparam logic [TICK_W-1:0] QUANTUM_RESET = 16'd1000;

	localparam logic [OP_W-1:0] OP_ADMIT   = 3'd0;
	localparam logic [OP_W-1:0] OP_IO_DONE = 3'd1;
	localparam logic [OP_W-1:0] OP_TICK    = 3'd2;
	localparam logic [OP_W-1:0] OP_IO_REQ  = 3'd3;
	localparam logic [OP_W-1:0] OP_TERM    = 3'd4;

	localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
	localparam logic [EV_W-1:0] EV_DISPATCH = 3'd1;
	localparam logic [EV_W-1:0] EV_PREEMPT  = 3'd2;
	localparam logic [EV_W-1:0] EV_DROPPED  = 3'd3;
	localparam logic [EV_W-1:0] EV_IDLE     = 3'd4;

	localparam logic ADDR_POLICY  = 1'b0;
	localparam logic ADDR_QUANTUM = 1'b1;

	typedef struct packed {
		logic [PID_W-1:0] pid;
		logic [PRI_W-1:0] pri;
	} entry_t;

	typedef struct packed {
		logic   wr_en;
		entry_t wr_data;
	} store_req_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TICK_RD,
		S_TICK_EV,
		S_INS,
		S_INS_EV,
		S_FINAL,
		S_POP_EV,
		S_DONE
	} state_t;

endpackage

>>> src/rrps_in_if.sv
// Input channel: one scheduling request per transaction.
// Depends on rrps_pkg for field widths.
`timescale 1ns / 1ps

interface rrps_in_if;
	import rrps_pkg::*;

	logic             valid;
	logic             ready;
	logic [OP_W-1:0]  operation;
	logic [PID_W-1:0] process_id;
	logic [PRI_W-1:0] priority_value;

	modport source (output valid, operation, process_id, priority_value, input ready);
	modport sink   (input valid, operation, process_id, priority_value, output ready);
endinterface

>>> src/rrps_out_if.sv
// Output channel: one scheduling result per transaction.
// Depends on rrps_pkg for field widths; COUNT_W sizes the waiting count.
`timescale 1ns / 1ps

interface rrps_out_if #(
	parameter int COUNT_W = 7
);
	import rrps_pkg::*;

	logic               valid;
	logic               ready;
	logic [EV_W-1:0]    event_code;
	logic [PID_W-1:0]   running_id;
	logic [PRI_W-1:0]   running_level;
	logic [COUNT_W-1:0] waiting_count;

	modport source (output valid, event_code, running_id, running_level, waiting_count,
		input ready);
	modport sink   (input valid, event_code, running_id, running_level, waiting_count,
		output ready);
endinterface

>>> src/round_robin_priority_scheduler_top.sv
// Ready-queue scheduler top: APB registers, sequencer, CPU state, result register.
// Depends on rrps_pkg, rrps_in_if, rrps_out_if, rrps_store and the defines header.
//
//  port     dir   kind            transaction
//  in_ch    sink  valid/ready     operation, process_id, priority_value
//  out_ch   src   valid/ready     event_code, running_id, running_level, waiting_count
//  apb      sink  psel/penable    policy_mode at 0x0, slice_quantum at 0x4
//
// One request at a time. A priority insert walks the store entry by entry through its
// single memory port. An output register holds the result, so the next request is taken
// while it waits. No clearing pass: the count gates every read.
`timescale 1ns / 1ps
`include "round_robin_priority_scheduler_top_defines.svh"

module round_robin_priority_scheduler_top #(
	parameter int QUEUE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	rrps_in_if.sink     in_ch,
	rrps_out_if.source  out_ch
);
	import rrps_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

	state_t state_q, state_d;

	logic              mode_q;
	logic [TICK_W-1:0] quantum_q;
	logic [AW-1:0]     head_q;
	logic [CW-1:0]     count_q;
	logic              busy_q;
	entry_t            cpu_q;
	logic [TICK_W-1:0] ticks_q;

	logic [OP_W-1:0]   op_q;
	entry_t            item_q;
	entry_t            carry_q;
	logic [PRI_W-1:0]  key_pri_q;
	logic [CW-1:0]     idx_q;
	logic              found_q;
	logic [EV_W-1:0]   ev_q;
	logic              drop_q;

	logic              out_valid_q;
	logic [EV_W-1:0]   out_ev_q;
	entry_t            out_cpu_q;
	logic [CW-1:0]     out_count_q;

	store_req_t        sreq;
	logic [CW-1:0]     soff;
	entry_t            rdata;

	logic              cfg_wr;
	logic              in_acc;
	logic              out_free;
	logic              ins_write;
	logic              ins_shift;
	logic              keep;
	logic [TICK_W-1:0] ticks_inc;
	logic [AW-1:0]     head_inc;
	logic [EV_W-1:0]   ev_final;

	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite;
	assign prdata   = (paddr[2] == ADDR_QUANTUM) ? {16'b0, quantum_q} : {31'b0, mode_q};
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_free = !out_valid_q || out_ch.ready;

	assign ticks_inc = ticks_q + 1'b1;
	assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign ins_write = !mode_q || (idx_q == count_q);
	assign ins_shift = found_q || (rdata.pri > key_pri_q);
	assign keep      = mode_q && (cpu_q.pri < rdata.pri);

	always_comb begin
		if (drop_q) begin
			ev_final = EV_DROPPED;
		end else if (ev_q == EV_NONE && !busy_q) begin
			ev_final = EV_IDLE;
		end else begin
			ev_final = ev_q;
		end
	end

	rrps_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.AW(AW)
	) u_store (
		.clk(clk),
		.head(head_q),
		.offset(soff[AW-1:0]),
		.req(sreq),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ch.ready  = 1'b0;
		sreq.wr_en   = 1'b0;
		sreq.wr_data = carry_q;
		soff         = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				priority case (op_q)
					OP_ADMIT, OP_IO_DONE: begin
						state_d = (count_q == DEPTH_C) ? S_FINAL : S_INS;
					end
					OP_TICK: begin
						if (busy_q && ticks_inc >= quantum_q && count_q != '0) begin
							state_d = S_TICK_RD;
						end else begin
							state_d = S_FINAL;
						end
					end
					default: begin
						state_d = S_FINAL;
					end
				endcase
			end
			S_TICK_RD: begin
				state_d = S_TICK_EV;
			end
			S_TICK_EV: begin
				state_d = keep ? S_FINAL : S_INS;
			end
			S_INS: begin
				if (ins_write) begin
					sreq.wr_en = 1'b1;
					soff       = count_q;
					state_d    = S_FINAL;
				end else begin
					soff    = idx_q;
					state_d = S_INS_EV;
				end
			end
			S_INS_EV: begin
				soff = idx_q;
				if (ins_shift) begin
					sreq.wr_en = 1'b1;
				end
				state_d = S_INS;
			end
			S_FINAL: begin
				state_d = (!busy_q && count_q != '0) ? S_POP_EV : S_DONE;
			end
			S_POP_EV: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= 1'b0;
			quantum_q <= QUANTUM_RESET;
		end else if (cfg_wr) begin
			if (paddr[2] == ADDR_POLICY) begin
				mode_q <= pwdata[0];
			end else begin
				quantum_q <= pwdata[TICK_W-1:0];
			end
		end
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
			cpu_q   <= '0;
			ticks_q <= '0;
		end else begin
			unique case (state_q)
				S_EXEC: begin
					if (op_q == OP_TICK && busy_q) begin
						ticks_q <= (ticks_inc >= quantum_q && count_q == '0) ? '0 : ticks_inc;
					end else if ((op_q == OP_IO_REQ || op_q == OP_TERM) && busy_q) begin
						busy_q  <= 1'b0;
						cpu_q   <= '0;
						ticks_q <= '0;
					end
				end
				S_TICK_EV: begin
					ticks_q <= '0;
					if (!keep) begin
						cpu_q   <= rdata;
						head_q  <= head_inc;
						count_q <= count_q - 1'b1;
					end
				end
				S_INS: begin
					if (ins_write) begin
						count_q <= count_q + 1'b1;
					end
				end
				S_POP_EV: begin
					cpu_q   <= rdata;
					busy_q  <= 1'b1;
					ticks_q <= '0;
					head_q  <= head_inc;
					count_q <= count_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// per-transaction working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					op_q       <= in_ch.operation;
					item_q.pid <= in_ch.process_id;
					item_q.pri <= in_ch.priority_value;
					ev_q       <= EV_NONE;
					drop_q     <= 1'b0;
				end
			end
			S_EXEC: begin
				carry_q   <= item_q;
				key_pri_q <= item_q.pri;
				idx_q     <= '0;
				found_q   <= 1'b0;
				if ((op_q == OP_ADMIT || op_q == OP_IO_DONE) && count_q == DEPTH_C) begin
					drop_q <= 1'b1;
				end
				if (op_q == OP_TICK && busy_q && ticks_inc >= quantum_q) begin
					ev_q <= EV_PREEMPT;
				end
			end
			S_TICK_EV: begin
				carry_q   <= cpu_q;
				key_pri_q <= cpu_q.pri;
			end
			S_INS_EV: begin
				if (ins_shift) begin
					carry_q <= rdata;
					found_q <= 1'b1;
				end
				idx_q <= idx_q + 1'b1;
			end
			S_POP_EV: begin
				if (ev_q == EV_NONE) begin
					ev_q <= EV_DISPATCH;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_ev_q    <= ev_final;
			out_cpu_q   <= cpu_q;
			out_count_q <= count_q;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.event_code    = out_ev_q;
	assign out_ch.running_id    = out_cpu_q.pid;
	assign out_ch.running_level = out_cpu_q.pri;
	assign out_ch.waiting_count = out_count_q;

	`RRPS_ASSERT_NEXT(a_accept_starts, in_acc, state_q == S_EXEC, "accept did not start work")
	`RRPS_ASSERT_SAME(a_count_bound, 1'b1, count_q <= DEPTH_C, "waiting count past depth")
	`RRPS_ASSERT_SAME(a_idle_clear, !busy_q, cpu_q == '0, "idle CPU holds a process")
	`RRPS_ASSERT_SAME(a_no_idle_wait, state_q == S_DONE, busy_q || count_q == '0,
		"CPU left idle with entries waiting")

endmodule

>>> src/rrps_store.sv
// Ready store: circular single-port memory of process entries.
// Depends on rrps_pkg; slot is (head + offset) modulo the depth.
`timescale 1ns / 1ps

module rrps_store #(
	parameter int QUEUE_DEPTH = 64,
	parameter int AW = 6
) (
	input  logic                clk,
	input  logic [AW-1:0]       head,
	input  logic [AW-1:0]       offset,
	input  rrps_pkg::store_req_t req,
	output rrps_pkg::entry_t    rdata
);
	import rrps_pkg::*;

	localparam logic [AW:0] DEPTH_W = (AW+1)'(QUEUE_DEPTH);

	entry_t      mem [QUEUE_DEPTH];
	entry_t      rdata_q;
	logic [AW:0] sum;
	logic [AW:0] slot;

	always_comb begin
		sum  = {1'b0, head} + {1'b0, offset};
		slot = (sum >= DEPTH_W) ? (sum - DEPTH_W) : sum;
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[slot[AW-1:0]] <= req.wr_data;
		end
		rdata_q <= mem[slot[AW-1:0]];
	end

	assign rdata = rdata_q;

endmodule
